>>> hw/rtl/upcbw_pkg.sv
// shared types and constants for the upc bar width capture block
package upcbw_pkg;

	// scan phase codes
	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_LGUARD = 3'd1,
		PH_LDIGIT = 3'd2,
		PH_CGUARD = 3'd3,
		PH_RDIGIT = 3'd4,
		PH_RGUARD = 3'd5
	} phase_t;

	// result kinds
	typedef enum logic {
		EV_DIGIT    = 1'b0,
		EV_COMPLETE = 1'b1
	} event_t;

	localparam int DIGIT_TOTAL  = 12;
	localparam int DIGIT_W      = 4;
	localparam int EDGE_W       = 3;
	localparam int RUN_W        = 16;
	localparam int TIMEOUT_W    = 16;
	localparam int LEN_OUT_W    = 16;
	localparam int ELEM_STORED  = 3;

	localparam logic [EDGE_W-1:0]    GUARD_EDGES  = 3'd3;
	localparam logic [EDGE_W-1:0]    DIGIT_EDGES  = 3'd4;
	localparam logic [EDGE_W-1:0]    CENTRE_EDGES = 3'd5;
	localparam logic [EDGE_W-1:0]    EDGE_MAX     = 3'd7;
	localparam logic [EDGE_W-1:0]    FOURTH_SLOT  = 3'd3;
	localparam logic [DIGIT_W-1:0]   HALF_DIGITS  = 4'd6;
	localparam logic [DIGIT_W-1:0]   ALL_DIGITS   = 4'd12;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd80;

endpackage

>>> hw/rtl/upc_bar_width_capture.sv
// upc-a bar width capture: run length measurement and guard/digit phase tracking
// an accepted sample sits in the input register and its result is loaded into the
//   output register when stage 1 moves on
// throughput: one sample per cycle while results are taken; a stalled result only
//   holds back a sample that itself produces a result
// reset: async active low, clears phase, levels, counters, lengths and timeout to 80
module upc_bar_width_capture
	import upcbw_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TIMEOUT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 event_res,
	output logic [DIGIT_W-1:0]   digit_index,
	output logic [LEN_OUT_W-1:0] width_first,
	output logic [LEN_OUT_W-1:0] width_second,
	output logic [LEN_OUT_W-1:0] width_third,
	output logic [LEN_OUT_W-1:0] width_fourth
);

	localparam int CW = (LENGTH_BITS > RUN_W) ? LENGTH_BITS : RUN_W;

	// configuration
	logic [TIMEOUT_W-1:0] timeout_q;

	// input stage
	logic sample_valid_s1;
	logic sample_s1;

	// scan state
	phase_t                 phase_q;
	logic                   level_q;
	logic [RUN_W-1:0]       run_q;
	logic [EDGE_W-1:0]      edge_q;
	logic [DIGIT_W-1:0]     digit_q;
	logic [LENGTH_BITS-1:0] lens_q [ELEM_STORED];

	// result register
	logic                   out_valid_q;
	event_t                 event_q;
	logic [DIGIT_W-1:0]     index_q;
	logic [LENGTH_BITS-1:0] w1_q, w2_q, w3_q, w4_q;

	// next-state logic
	logic                   edge_seen;
	logic [EDGE_W-1:0]      edge_cnt;
	logic [CW-1:0]          run_ext;
	logic [CW-1:0]          len_top;
	logic [CW-1:0]          clip_w;
	logic [LENGTH_BITS-1:0] clip_len;
	logic [LENGTH_BITS-1:0] fourth_len;
	logic [LENGTH_BITS-1:0] lens_n [ELEM_STORED];
	logic [RUN_W:0]         run_inc;
	logic [DIGIT_W-1:0]     digit_inc;
	phase_t                 phase_n;
	logic [EDGE_W-1:0]      edge_n;
	logic [DIGIT_W-1:0]     digit_n;
	logic [RUN_W-1:0]       run_n;
	logic                   res;
	event_t                 res_ev;
	logic                   adv;

	// config write is taken at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	// handshake: stage 1 moves on unless its result finds the output full
	assign adv       = sample_valid_s1 && (!res || !out_valid_q || out_ready);
	assign in_ready  = !sample_valid_s1 || adv;
	assign out_valid = out_valid_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			sample_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
		end
	end

	// edge detect, saturating element length and edge count
	always_comb begin
		edge_seen = sample_s1 ^ level_q;
		edge_cnt  = (edge_seen && edge_q != EDGE_MAX) ? edge_q + 1'b1 : edge_q;
		run_ext   = CW'(run_q);
		len_top   = {CW{1'b1}} >> (CW - LENGTH_BITS);
		clip_w    = (run_ext > len_top) ? len_top : run_ext;
		clip_len  = LENGTH_BITS'(clip_w);
		for (int i = 0; i < ELEM_STORED; i++) begin
			lens_n[i] = (edge_seen && edge_q == EDGE_W'(i)) ? clip_len : lens_q[i];
		end
		fourth_len = (edge_seen && edge_q == FOURTH_SLOT) ? clip_len : '0;
		run_inc    = edge_seen ? (RUN_W+1)'(1) : {1'b0, run_q} + 1'b1;
		digit_inc  = digit_q + 1'b1;
	end

	// phase machine and timeout
	always_comb begin
		phase_n = phase_q;
		edge_n  = edge_cnt;
		digit_n = digit_q;
		res     = 1'b0;
		res_ev  = EV_DIGIT;
		unique case (phase_q)
			PH_LGUARD: begin
				if (edge_cnt == GUARD_EDGES) begin
					phase_n = PH_LDIGIT;
					edge_n  = '0;
					digit_n = '0;
				end
			end
			PH_LDIGIT, PH_RDIGIT: begin
				if (edge_cnt == DIGIT_EDGES) begin
					res     = 1'b1;
					digit_n = digit_inc;
					edge_n  = '0;
					if (phase_q == PH_LDIGIT && digit_inc == HALF_DIGITS) begin
						phase_n = PH_CGUARD;
					end else if (phase_q == PH_RDIGIT && digit_inc == ALL_DIGITS) begin
						phase_n = PH_RGUARD;
					end
				end
			end
			PH_CGUARD: begin
				if (edge_cnt == CENTRE_EDGES) begin
					phase_n = PH_RDIGIT;
					edge_n  = '0;
				end
			end
			PH_RGUARD: begin
				if (edge_cnt == GUARD_EDGES) begin
					phase_n = PH_WAIT;
					res     = 1'b1;
					res_ev  = EV_COMPLETE;
				end
			end
			default: begin
				phase_n = PH_WAIT;
				if (!level_q && sample_s1) begin
					phase_n = PH_LGUARD;
					edge_n  = '0;
				end
			end
		endcase
		run_n = RUN_W'(run_inc);
		if (run_inc > {1'b0, timeout_q}) begin
			edge_n  = '0;
			run_n   = '0;
			phase_n = PH_WAIT;
		end
	end

	// scan state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			level_q <= 1'b0;
			run_q   <= '0;
			edge_q  <= '0;
			digit_q <= '0;
			for (int i = 0; i < ELEM_STORED; i++) begin
				lens_q[i] <= '0;
			end
		end else if (adv) begin
			phase_q <= phase_n;
			level_q <= sample_s1;
			run_q   <= run_n;
			edge_q  <= edge_n;
			digit_q <= digit_n;
			for (int i = 0; i < ELEM_STORED; i++) begin
				lens_q[i] <= lens_n[i];
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, zeros for scan complete
	always_ff @(posedge clk) begin
		if (adv && res) begin
			event_q <= res_ev;
			if (res_ev == EV_COMPLETE) begin
				index_q <= '0;
				w1_q    <= '0;
				w2_q    <= '0;
				w3_q    <= '0;
				w4_q    <= '0;
			end else begin
				index_q <= digit_q;
				w1_q    <= lens_n[0];
				w2_q    <= lens_n[1];
				w3_q    <= lens_n[2];
				w4_q    <= fourth_len;
			end
		end
	end

	assign event_res    = event_q;
	assign digit_index  = index_q;
	assign width_first  = LEN_OUT_W'(w1_q);
	assign width_second = LEN_OUT_W'(w2_q);
	assign width_third  = LEN_OUT_W'(w3_q);
	assign width_fourth = LEN_OUT_W'(w4_q);

endmodule
